FILE: design/gero3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 grayscale erosion unit.
// Used by gero3_window and grayscale_erosion_3x3_unit; depends on nothing.
package gero3_pkg;

	// default sizing, handed to the top level parameters
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int PIXEL_BITS_DEF = 8;

	// configuration port
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int PAD_W      = 8;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE    = 2'd2;

	localparam int CFG_WIDTH_RESET  = 1024;
	localparam int CFG_HEIGHT_RESET = 1024;
	localparam logic [PAD_W-1:0] CFG_PAD_RESET = 8'd255;

	// result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 2);

	// which sides of the 3x3 neighborhood fall outside the frame
	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bottom;
	} edge_mask_t;

	typedef struct packed {
		logic       shift;
		edge_mask_t mask;
	} win_ctrl_t;

endpackage

FILE: design/grayscale_erosion_3x3_unit.sv
`timescale 1ns / 1ps
// Streaming 3x3 grayscale erosion. Throughput: one item per clock while in_stall is low, with
// one read and one write of the line memory per cycle. The result of pixel j is formed in
// stage 1 from the item carrying pixel j+W+1 and written into the result queue, where it
// raises out_valid. Reset clears counters, window and result queue and loads width
// 1024, height 1024, pad 255, capped at MAX_WIDTH and MAX_HEIGHT; the line memory
// holds no reset value. Depends on gero3_pkg and gero3_window.
module grayscale_erosion_3x3_unit #(
	parameter int MAX_WIDTH  = gero3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = gero3_pkg::MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = gero3_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [gero3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gero3_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel stream in
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [PIXEL_BITS-1:0]               pixel_in,
	input  logic                                flush_tick,
	// eroded stream out
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [PIXEL_BITS-1:0]               eroded_pixel,
	output logic                                frame_last
);

	localparam int CW  = $clog2(MAX_WIDTH);        // column index
	localparam int WW  = $clog2(MAX_WIDTH + 1);    // width value 1..MAX_WIDTH
	localparam int PW  = $clog2(MAX_WIDTH + 2);    // priming count 0..W+1
	localparam int HW  = $clog2(MAX_HEIGHT);       // output row index
	localparam int HW1 = $clog2(MAX_HEIGHT + 1);   // height value
	localparam int RW  = $clog2(MAX_HEIGHT + 2);   // input row, runs past H while draining
	localparam int W_RST = (gero3_pkg::CFG_WIDTH_RESET > MAX_WIDTH) ?
		MAX_WIDTH : gero3_pkg::CFG_WIDTH_RESET;
	localparam int H_RST = (gero3_pkg::CFG_HEIGHT_RESET > MAX_HEIGHT) ?
		MAX_HEIGHT : gero3_pkg::CFG_HEIGHT_RESET;
	localparam int DEPTH = gero3_pkg::FIFO_DEPTH;

	// ---------------------------------------------------------------------
	// Configuration registers, saturated on write
	// ---------------------------------------------------------------------
	logic [WW-1:0]                  w_q;
	logic [HW1-1:0]                 h_q;
	logic [gero3_pkg::PAD_W-1:0]    pad_q;
	logic [WW-1:0]                  w_sat;
	logic [HW1-1:0]                 h_sat;
	logic                           cfg_hit;
	logic [PIXEL_BITS-1:0]          pad_px;

	always_comb begin
		if (cfg_data == '0)
			w_sat = WW'(1);
		else if (32'(cfg_data) > 32'(MAX_WIDTH))
			w_sat = WW'(MAX_WIDTH);
		else
			w_sat = WW'(cfg_data);
		if (cfg_data == '0)
			h_sat = HW1'(1);
		else if (32'(cfg_data) > 32'(MAX_HEIGHT))
			h_sat = HW1'(MAX_HEIGHT);
		else
			h_sat = HW1'(cfg_data);
	end

	// a write to an index beyond the register list leaves everything alone
	assign cfg_hit = cfg_write && (cfg_index == gero3_pkg::REG_IMAGE_WIDTH ||
		cfg_index == gero3_pkg::REG_IMAGE_HEIGHT || cfg_index == gero3_pkg::REG_PAD_VALUE);
	assign pad_px = PIXEL_BITS'(pad_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WW'(W_RST);
			h_q   <= HW1'(H_RST);
			pad_q <= gero3_pkg::CFG_PAD_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gero3_pkg::REG_IMAGE_WIDTH:  w_q   <= w_sat;
				gero3_pkg::REG_IMAGE_HEIGHT: h_q   <= h_sat;
				gero3_pkg::REG_PAD_VALUE:    pad_q <= cfg_data[gero3_pkg::PAD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Stage 0: take the beat, walk the raster counters, issue the line read
	// ---------------------------------------------------------------------
	logic [CW-1:0]  in_col_q;
	logic [RW-1:0]  in_row_q;
	logic [PW-1:0]  pre_q;        // items taken so far, held once it reaches W+1
	logic [CW-1:0]  out_col_q;
	logic [HW-1:0]  out_row_q;

	logic                    acc;
	logic                    take;
	logic                    incomplete;
	logic [PIXEL_BITS-1:0]   px0;
	logic                    col_wrap;
	logic                    has_res;
	logic                    c_last;
	logic                    r_last;
	logic                    last0;
	gero3_pkg::edge_mask_t   mask0;

	// stage 1 signals, declared here for the forwarding compare
	logic                          v_s1;
	logic                          res_s1;
	logic                          last_s1;
	logic [PIXEL_BITS-1:0]         px_s1;
	logic [CW-1:0]                 col_s1;
	gero3_pkg::edge_mask_t         mask_s1;
	logic                          hit_s1;
	logic [2*PIXEL_BITS-1:0]       fwd_s1;
	logic [2*PIXEL_BITS-1:0]       rd_q;
	logic [2*PIXEL_BITS-1:0]       rd_eff;
	logic [2*PIXEL_BITS-1:0]       wr_data;

	// result queue occupancy
	logic [gero3_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic [gero3_pkg::FIFO_CNT_W-1:0] occ;

	// stall only when the queue plus the beat in flight could run out of room;
	// never looks at out_stall, so a waiting result blocks the input only once the queue fills
	assign occ      = cnt_q + gero3_pkg::FIFO_CNT_W'(v_s1);
	assign in_stall = occ >= gero3_pkg::FIFO_CNT_W'(DEPTH);
	assign acc      = in_valid && !in_stall;

	assign incomplete = in_row_q < RW'(h_q);
	// an early flush is swallowed: no push, no state change
	assign take     = acc && !(flush_tick && incomplete);
	assign px0      = incomplete ? pixel_in : pad_px;
	assign col_wrap = (WW'(in_col_q) + WW'(1)) == w_q;
	assign has_res  = pre_q == (PW'(w_q) + PW'(1));
	assign c_last   = (WW'(out_col_q) + WW'(1)) == w_q;
	assign r_last   = (HW1'(out_row_q) + HW1'(1)) == h_q;
	assign last0    = has_res && c_last && r_last;

	assign mask0.left   = out_col_q == '0;
	assign mask0.right  = c_last;
	assign mask0.top    = out_row_q == '0;
	assign mask0.bottom = r_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			pre_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_hit || (take && last0)) begin
			// abandon the frame on a register write, rearm after the last result
			in_col_q  <= '0;
			in_row_q  <= '0;
			pre_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (take) begin
			in_col_q <= col_wrap ? '0 : in_col_q + CW'(1);
			in_row_q <= in_row_q + RW'(col_wrap);
			if (has_res) begin
				out_col_q <= c_last ? '0 : out_col_q + CW'(1);
				out_row_q <= out_row_q + HW'(c_last);
			end else begin
				pre_q <= pre_q + PW'(1);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Line memory: {upper line, lower line} per column, one read, one write
	// ---------------------------------------------------------------------
	logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (v_s1)
			line_mem[col_s1] <= wr_data;
		if (take)
			rd_q <= line_mem[in_col_q];
	end

	// ---------------------------------------------------------------------
	// Stage 1: merge the read with a same-column write, rotate lines, shift window
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			res_s1  <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			v_s1    <= take;
			res_s1  <= take && has_res;
			last_s1 <= take && last0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_s1   <= px0;
			col_s1  <= in_col_q;
			mask_s1 <= mask0;
			// the read sees old data when stage 1 writes the same column now
			hit_s1  <= v_s1 && (col_s1 == in_col_q);
			fwd_s1  <= wr_data;
		end
	end

	assign rd_eff  = hit_s1 ? fwd_s1 : rd_q;
	// lower line moves up, the new pixel becomes the lower line
	assign wr_data = {rd_eff[PIXEL_BITS-1:0], px_s1};

	gero3_pkg::win_ctrl_t           win_ctrl;
	logic [2:0][PIXEL_BITS-1:0]     win_col;
	logic [PIXEL_BITS-1:0]          min_px;

	assign win_ctrl.shift = v_s1;
	assign win_ctrl.mask  = mask_s1;
	assign win_col[0]     = rd_eff[2*PIXEL_BITS-1:PIXEL_BITS];
	assign win_col[1]     = rd_eff[PIXEL_BITS-1:0];
	assign win_col[2]     = px_s1;

	gero3_window #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (win_ctrl),
		.col_in (win_col),
		.pad    (pad_px),
		.min_px (min_px)
	);

	// ---------------------------------------------------------------------
	// Result queue: decouples the output handshake from the pipeline
	// ---------------------------------------------------------------------
	logic [PIXEL_BITS:0]                fifo_q [DEPTH];
	logic [gero3_pkg::FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [gero3_pkg::FIFO_PTR_W-1:0]   rd_ptr_q;
	logic                               push;
	logic                               pop;

	assign push = res_s1;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= {last_s1, min_px};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + gero3_pkg::FIFO_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + gero3_pkg::FIFO_PTR_W'(1);
			cnt_q <= cnt_q + gero3_pkg::FIFO_CNT_W'(push) - gero3_pkg::FIFO_CNT_W'(pop);
		end
	end

	assign out_valid    = cnt_q != '0;
	assign eroded_pixel = fifo_q[rd_ptr_q][PIXEL_BITS-1:0];
	assign frame_last   = fifo_q[rd_ptr_q][PIXEL_BITS];

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gero3_pkg::FIFO_CNT_W'(DEPTH))
		else $error("result queue holds more than its depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < gero3_pkg::FIFO_CNT_W'(DEPTH)) || pop)
		else $error("result pushed into a full queue");

	a_last_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		last_s1 |-> res_s1 && v_s1)
		else $error("frame end flagged on a beat without a result");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		take && last0 |=> in_col_q == '0 && in_row_q == '0 && pre_q == '0 &&
			out_col_q == '0 && out_row_q == '0)
		else $error("counters not cleared after the last result of a frame");

endmodule

FILE: design/gero3_window.sv
`timescale 1ns / 1ps
// 3x3 window of the erosion unit: holds the two newest columns and forms the
// masked minimum with the incoming column. Depends on gero3_pkg.
module gero3_window #(
	parameter int PIXEL_BITS = gero3_pkg::PIXEL_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  gero3_pkg::win_ctrl_t           ctrl,
	input  logic [2:0][PIXEL_BITS-1:0]     col_in,   // [0] top, [1] middle, [2] bottom
	input  logic [PIXEL_BITS-1:0]          pad,
	output logic [PIXEL_BITS-1:0]          min_px
);

	// win_q[0]: older column, win_q[1]: newest column
	logic [1:0][2:0][PIXEL_BITS-1:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctrl.shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= col_in;
		end
	end

	// minimum over the window as it stands after the shift
	always_comb begin
		logic [8:0][PIXEL_BITS-1:0] vals;
		logic [8:0]                 outside;
		logic [PIXEL_BITS-1:0]      x;
		logic [PIXEL_BITS-1:0]      m;
		for (int r = 0; r < 3; r++) begin
			vals[r]     = win_q[0][r];
			vals[3 + r] = win_q[1][r];
			vals[6 + r] = col_in[r];
			outside[r]     = ctrl.mask.left;
			outside[3 + r] = 1'b0;
			outside[6 + r] = ctrl.mask.right;
		end
		for (int c = 0; c < 3; c++) begin
			outside[3*c]     = outside[3*c] | ctrl.mask.top;
			outside[3*c + 2] = outside[3*c + 2] | ctrl.mask.bottom;
		end
		m = vals[4];
		for (int i = 0; i < 9; i++) begin
			x = outside[i] ? pad : vals[i];
			if (x < m) m = x;
		end
		min_px = m;
	end

endmodule
